FILE: sv/ifrt_pkg.sv
package ifrt_pkg;

    localparam int SLOT_COUNT_DEF   = 8;
    localparam int MAX_DATAGRAM_DEF = 65535;

    localparam int OFFSET_BITS = 13;
    localparam int MORE_BIT    = 13;

    localparam logic [15:0] TIMEOUT_RST = 16'd5000;
    localparam logic [15:0] CLEANUP_RST = 16'd1000;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLEANUP = 1'd1;

    localparam logic KIND_FRAG = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [2:0] {
        STATUS_PASS     = 3'd0,
        STATUS_DROP     = 3'd1,
        STATUS_STORED   = 3'd2,
        STATUS_COMPLETE = 3'd3,
        STATUS_TICK     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    // lookup word walking along the slot cells
    typedef struct packed {
        logic        valid;
        logic        kind;
        logic        sweep;
        logic [31:0] now;
        logic [31:0] src;
        logic [15:0] ident;
        logic        found;
        logic [15:0] hw;
        logic [15:0] expected;
        logic        free_found;
    } tok_t;

    // slot update broadcast at the end of a fragment
    typedef struct packed {
        logic        en;
        logic        alloc;
        logic        used;
        logic [31:0] src;
        logic [15:0] ident;
        logic [31:0] deadline;
        logic [15:0] hw;
        logic [15:0] expected;
    } commit_t;

endpackage

FILE: sv/ifrt_if.sv
interface ifrt_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] now_ms;
    logic [31:0] src_addr;
    logic [15:0] ident;
    logic [15:0] frag_word;
    logic [3:0]  header_words;
    logic [15:0] total_length;

    modport source (
        output valid, kind, now_ms, src_addr, ident, frag_word, header_words, total_length,
        input  ready
    );
    modport sink (
        input  valid, kind, now_ms, src_addr, ident, frag_word, header_words, total_length,
        output ready
    );
endinterface

interface ifrt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [2:0]  slot_index;
    logic        copy_payload;
    logic [15:0] write_offset;
    logic [15:0] copy_length;
    logic [15:0] reassembled_length;
    logic [7:0]  expired_mask;

    modport source (
        output valid, status, slot_index, copy_payload, write_offset, copy_length,
               reassembled_length, expired_mask,
        input  ready
    );
    modport sink (
        input  valid, status, slot_index, copy_payload, write_offset, copy_length,
               reassembled_length, expired_mask,
        output ready
    );
endinterface

FILE: sv/ifrt_cell.sv
module ifrt_cell #(
    parameter int SLOT_COUNT = ifrt_pkg::SLOT_COUNT_DEF,
    parameter int CELL_IDX   = 0,
    localparam int IDX_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ifrt_pkg::tok_t        up_tok,
    input  logic [IDX_W-1:0]      up_match,
    input  logic [IDX_W-1:0]      up_free,
    input  logic [SLOT_COUNT-1:0] up_mask,
    output ifrt_pkg::tok_t        dn_tok,
    output logic [IDX_W-1:0]      dn_match,
    output logic [IDX_W-1:0]      dn_free,
    output logic [SLOT_COUNT-1:0] dn_mask,
    input  ifrt_pkg::commit_t     commit,
    input  logic [IDX_W-1:0]      commit_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                  used_reg, used_next;
    logic [31:0]           src_reg;
    logic [15:0]           ident_reg;
    logic [15:0]           hw_reg;
    logic [15:0]           exp_reg;
    logic [31:0]           deadline_reg;

    ifrt_pkg::tok_t        tok_reg, tok_next;
    logic [IDX_W-1:0]      match_reg, match_next;
    logic [IDX_W-1:0]      free_reg, free_next;
    logic [SLOT_COUNT-1:0] mask_reg, mask_next;

    logic hit;
    logic vacant;
    logic expire;
    logic wr;

    always_comb
    begin
        hit    = up_tok.valid && (up_tok.kind == ifrt_pkg::KIND_FRAG) && !up_tok.found
                 && used_reg && (src_reg == up_tok.src) && (ident_reg == up_tok.ident);
        vacant = up_tok.valid && (up_tok.kind == ifrt_pkg::KIND_FRAG) && !up_tok.free_found
                 && !used_reg;
        expire = up_tok.valid && (up_tok.kind == ifrt_pkg::KIND_TICK) && up_tok.sweep
                 && used_reg && (up_tok.now > deadline_reg);
        wr     = commit.en && (commit_idx == MY_IDX);

        tok_next   = up_tok;
        match_next = up_match;
        free_next  = up_free;
        mask_next  = up_mask;
        if (hit)
        begin
            tok_next.found    = 1'b1;
            tok_next.hw       = hw_reg;
            tok_next.expected = exp_reg;
            match_next        = MY_IDX;
        end
        if (vacant)
        begin
            tok_next.free_found = 1'b1;
            free_next           = MY_IDX;
        end
        if (expire)
        begin
            mask_next[CELL_IDX] = 1'b1;
        end

        used_next = used_reg;
        if (expire)
        begin
            used_next = 1'b0;
        end
        else if (wr)
        begin
            used_next = commit.used;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
        free_reg  <= free_next;
        mask_reg  <= mask_next;
        if (wr)
        begin
            hw_reg  <= commit.hw;
            exp_reg <= commit.expected;
            if (commit.alloc)
            begin
                src_reg      <= commit.src;
                ident_reg    <= commit.ident;
                deadline_reg <= commit.deadline;
            end
        end
    end

    assign dn_tok   = tok_reg;
    assign dn_match = match_reg;
    assign dn_free  = free_reg;
    assign dn_mask  = mask_reg;

endmodule

FILE: sv/ip_fragment_reassembly_tracker_top.sv
// Tracks IPv4 fragment reassembly over SLOT_COUNT slots held in a row of cells. Each word on
// req is a fragment or a housekeeping tick; each yields exactly one word on rsp. An accepted
// word walks the slot cells one cell per cycle, collecting the matching slot, the lowest
// free slot and, on a tick due for a sweep, the expired slots; the chosen slot is then
// updated and the result registered. req is ready only between items, while a finished
// result may still wait on rsp. The payload buffer itself lives outside; copy_payload,
// write_offset and copy_length tell it what to store. Configuration writes are taken at
// any time but are meant for idle periods.
module ip_fragment_reassembly_tracker_top #(
    parameter int SLOT_COUNT   = ifrt_pkg::SLOT_COUNT_DEF,
    parameter int MAX_DATAGRAM = ifrt_pkg::MAX_DATAGRAM_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    ifrt_req_if.sink                        req,
    ifrt_rsp_if.source                      rsp,
    input  logic                            cfg_we,
    input  logic [ifrt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ifrt_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    ifrt_pkg::state_t state_reg, state_next;

    logic [15:0] timeout_reg;
    logic [15:0] interval_reg;
    logic [31:0] last_sweep_reg;

    ifrt_pkg::tok_t inj_tok_reg;
    logic           more_reg;
    logic           pass_reg;
    logic [15:0]    offset_reg;
    logic [15:0]    payload_reg;
    logic [31:0]    deadline_reg;

    logic                  fin_found_reg;
    logic                  fin_free_found_reg;
    logic [15:0]           fin_hw_reg;
    logic [15:0]           fin_exp_reg;
    logic [IDX_W-1:0]      fin_match_reg;
    logic [IDX_W-1:0]      fin_free_reg;
    logic [SLOT_COUNT-1:0] fin_mask_reg;
    logic [16:0]           end_reg;

    logic        out_valid_reg;
    logic [2:0]  status_reg;
    logic [2:0]  slot_index_reg;
    logic        copy_reg;
    logic [15:0] wr_offset_reg;
    logic [15:0] copy_len_reg;
    logic [15:0] reasm_len_reg;
    logic [7:0]  exp_mask_reg;

    ifrt_pkg::tok_t        chain_tok   [SLOT_COUNT+1];
    logic [IDX_W-1:0]      chain_match [SLOT_COUNT+1];
    logic [IDX_W-1:0]      chain_free  [SLOT_COUNT+1];
    logic [SLOT_COUNT-1:0] chain_mask  [SLOT_COUNT+1];

    ifrt_pkg::commit_t commit;
    logic [IDX_W-1:0]  commit_idx;

    logic        accept;
    logic        scan_end;
    logic        load_out;
    logic [5:0]  hlen;
    logic [31:0] elapsed;

    logic                    have;
    logic [IDX_W-1:0]        sel;
    logic [15:0]             base_hw;
    logic [15:0]             base_exp;
    logic                    do_copy;
    logic [15:0]             new_hw;
    logic [15:0]             new_exp;
    logic                    complete;
    logic [IDX_W+2:0]        sel_ext;
    logic [SLOT_COUNT+7:0]   mask_ext;
    ifrt_pkg::status_t       status_sel;

    // cell chain
    assign chain_tok[0]   = inj_tok_reg;
    assign chain_match[0] = '0;
    assign chain_free[0]  = '0;
    assign chain_mask[0]  = '0;

    for (genvar g = 0; g < SLOT_COUNT; g++)
    begin : g_cell
        ifrt_cell #(
            .SLOT_COUNT (SLOT_COUNT),
            .CELL_IDX   (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_tok     (chain_tok[g]),
            .up_match   (chain_match[g]),
            .up_free    (chain_free[g]),
            .up_mask    (chain_mask[g]),
            .dn_tok     (chain_tok[g+1]),
            .dn_match   (chain_match[g+1]),
            .dn_free    (chain_free[g+1]),
            .dn_mask    (chain_mask[g+1]),
            .commit     (commit),
            .commit_idx (commit_idx)
        );
    end

    assign scan_end = chain_tok[SLOT_COUNT].valid;

    // control
    always_comb
    begin
        state_next = state_reg;
        accept     = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ifrt_pkg::S_IDLE:
            begin
                accept = req.valid;
                if (req.valid)
                begin
                    state_next = ifrt_pkg::S_SCAN;
                end
            end
            ifrt_pkg::S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ifrt_pkg::S_DONE;
                end
            end
            ifrt_pkg::S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ifrt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ifrt_pkg::S_IDLE;
            end
        endcase
    end

    assign req.ready = (state_reg == ifrt_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ifrt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration and sweep time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= ifrt_pkg::TIMEOUT_RST;
            interval_reg   <= ifrt_pkg::CLEANUP_RST;
            last_sweep_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ifrt_pkg::REG_TIMEOUT: timeout_reg  <= cfg_data;
                    ifrt_pkg::REG_CLEANUP: interval_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept && (req.kind == ifrt_pkg::KIND_TICK) && (elapsed > 32'(interval_reg)))
            begin
                last_sweep_reg <= req.now_ms;
            end
        end
    end

    // item capture
    assign hlen    = {req.header_words, 2'b00};
    assign elapsed = req.now_ms - last_sweep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inj_tok_reg <= '0;
        end
        else
        begin
            inj_tok_reg.valid <= accept;
            if (accept)
            begin
                inj_tok_reg.kind       <= req.kind;
                inj_tok_reg.sweep      <= (elapsed > 32'(interval_reg));
                inj_tok_reg.now        <= req.now_ms;
                inj_tok_reg.src        <= req.src_addr;
                inj_tok_reg.ident      <= req.ident;
                inj_tok_reg.found      <= 1'b0;
                inj_tok_reg.hw         <= '0;
                inj_tok_reg.expected   <= '0;
                inj_tok_reg.free_found <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            more_reg     <= req.frag_word[ifrt_pkg::MORE_BIT];
            pass_reg     <= (req.frag_word[ifrt_pkg::OFFSET_BITS-1:0] == '0)
                            && !req.frag_word[ifrt_pkg::MORE_BIT];
            offset_reg   <= {req.frag_word[ifrt_pkg::OFFSET_BITS-1:0], 3'b000};
            payload_reg  <= (req.total_length > 16'(hlen))
                            ? (req.total_length - 16'(hlen)) : '0;
            deadline_reg <= req.now_ms + 32'(timeout_reg);
        end
        if (scan_end)
        begin
            fin_found_reg      <= chain_tok[SLOT_COUNT].found;
            fin_free_found_reg <= chain_tok[SLOT_COUNT].free_found;
            fin_hw_reg         <= chain_tok[SLOT_COUNT].hw;
            fin_exp_reg        <= chain_tok[SLOT_COUNT].expected;
            fin_match_reg      <= chain_match[SLOT_COUNT];
            fin_free_reg       <= chain_free[SLOT_COUNT];
            fin_mask_reg       <= chain_mask[SLOT_COUNT];
            end_reg            <= {1'b0, offset_reg} + {1'b0, payload_reg};
        end
    end

    // slot update and result
    always_comb
    begin
        have     = fin_found_reg || fin_free_found_reg;
        sel      = fin_found_reg ? fin_match_reg : fin_free_reg;
        base_hw  = fin_found_reg ? fin_hw_reg : '0;
        base_exp = fin_found_reg ? fin_exp_reg : '0;
        do_copy  = (end_reg <= 17'(MAX_DATAGRAM));
        new_hw   = (do_copy && (end_reg > {1'b0, base_hw})) ? end_reg[15:0] : base_hw;
        if (more_reg)
        begin
            new_exp = base_exp;
        end
        else
        begin
            new_exp = end_reg[16] ? 16'hFFFF : end_reg[15:0];
        end
        complete = (new_exp != '0) && (new_hw >= new_exp);
        sel_ext  = (IDX_W+3)'(sel);
        mask_ext = (SLOT_COUNT+8)'(fin_mask_reg);

        priority if (inj_tok_reg.kind == ifrt_pkg::KIND_TICK)
        begin
            status_sel = ifrt_pkg::STATUS_TICK;
        end
        else if (pass_reg)
        begin
            status_sel = ifrt_pkg::STATUS_PASS;
        end
        else if (!have)
        begin
            status_sel = ifrt_pkg::STATUS_DROP;
        end
        else if (complete)
        begin
            status_sel = ifrt_pkg::STATUS_COMPLETE;
        end
        else
        begin
            status_sel = ifrt_pkg::STATUS_STORED;
        end

        commit.en       = load_out && ((status_sel == ifrt_pkg::STATUS_STORED)
                                    || (status_sel == ifrt_pkg::STATUS_COMPLETE));
        commit.alloc    = !fin_found_reg;
        commit.used     = !complete;
        commit.src      = inj_tok_reg.src;
        commit.ident    = inj_tok_reg.ident;
        commit.deadline = deadline_reg;
        commit.hw       = new_hw;
        commit.expected = new_exp;
        commit_idx      = sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg     <= status_sel;
            slot_index_reg <= '0;
            copy_reg       <= 1'b0;
            wr_offset_reg  <= '0;
            copy_len_reg   <= '0;
            reasm_len_reg  <= '0;
            exp_mask_reg   <= '0;
            if (status_sel == ifrt_pkg::STATUS_TICK)
            begin
                exp_mask_reg <= mask_ext[7:0];
            end
            if ((status_sel == ifrt_pkg::STATUS_STORED)
                || (status_sel == ifrt_pkg::STATUS_COMPLETE))
            begin
                slot_index_reg <= sel_ext[2:0];
                copy_reg       <= do_copy;
                wr_offset_reg  <= do_copy ? offset_reg : '0;
                copy_len_reg   <= do_copy ? payload_reg : '0;
                reasm_len_reg  <= complete ? new_exp : '0;
            end
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.status             = status_reg;
    assign rsp.slot_index         = slot_index_reg;
    assign rsp.copy_payload       = copy_reg;
    assign rsp.write_offset       = wr_offset_reg;
    assign rsp.copy_length        = copy_len_reg;
    assign rsp.reassembled_length = reasm_len_reg;
    assign rsp.expired_mask       = exp_mask_reg;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int SETTLE_CYCLES = 24;
    localparam int LIMIT_CYCLES  = 300000;
    localparam int IDLE_PCT      = 31;

    typedef struct packed {
        logic        kind;
        logic [31:0] now_ms;
        logic [31:0] src_addr;
        logic [15:0] ident;
        logic [15:0] frag_word;
        logic [3:0]  header_words;
        logic [15:0] total_length;
    } req_word_t;

    typedef struct packed {
        ifrt_pkg::status_t status;
        logic [2:0]        slot_index;
        logic              copy_payload;
        logic [15:0]       write_offset;
        logic [15:0]       copy_length;
        logic [15:0]       reassembled_length;
        logic [7:0]        expired_mask;
    } rsp_word_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [ifrt_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ifrt_pkg::CFG_DATA_W-1:0] cfg_data;

    ifrt_req_if req_bus ();
    ifrt_rsp_if rsp_bus ();

    ip_fragment_reassembly_tracker_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of the tracker state
    logic [15:0] cfg_timeout_ms;
    logic [15:0] cfg_sweep_gap_ms;
    logic        slot_used     [ifrt_pkg::SLOT_COUNT_DEF];
    logic [31:0] slot_src      [ifrt_pkg::SLOT_COUNT_DEF];
    logic [15:0] slot_ident    [ifrt_pkg::SLOT_COUNT_DEF];
    logic [15:0] slot_hw       [ifrt_pkg::SLOT_COUNT_DEF];
    logic [15:0] slot_expect   [ifrt_pkg::SLOT_COUNT_DEF];
    logic [31:0] slot_deadline [ifrt_pkg::SLOT_COUNT_DEF];
    logic [31:0] last_sweep_ms;

    req_word_t tx_backlog[$];
    req_word_t frag_batch[$];
    rsp_word_t outstanding_rsp[$];
    req_word_t on_bus;

    logic [31:0] wall_ms;
    logic        burst;
    int          words_queued;
    int          words_sent;
    int          words_seen;
    int          mismatches;
    int          n_reassembled;
    int          n_dropped;
    int          n_expired;
    int          n_sweeps;
    int          cycle_count;

    function automatic rsp_word_t predict_reassembly(req_word_t w);
        rsp_word_t   r;
        logic [31:0] elapsed;
        logic [15:0] hlen;
        logic [15:0] offset;
        logic [15:0] payload;
        logic [16:0] frag_end;
        logic        more;
        int          s;
        int          i;
        r = '0;
        if (w.kind == ifrt_pkg::KIND_TICK)
        begin
            r.status = ifrt_pkg::STATUS_TICK;
            elapsed = w.now_ms - last_sweep_ms;
            if (elapsed > {16'd0, cfg_sweep_gap_ms})
            begin
                n_sweeps++;
                for (i = 0; i < ifrt_pkg::SLOT_COUNT_DEF; i++)
                begin
                    if (slot_used[i] && w.now_ms > slot_deadline[i])
                    begin
                        slot_used[i] = 1'b0;
                        r.expired_mask[i] = 1'b1;
                        n_expired++;
                    end
                end
                last_sweep_ms = w.now_ms;
            end
            return r;
        end
        hlen     = {10'd0, w.header_words, 2'b00};
        offset   = {w.frag_word[ifrt_pkg::OFFSET_BITS-1:0], 3'b000};
        more     = w.frag_word[ifrt_pkg::MORE_BIT];
        payload  = (w.total_length > hlen) ? w.total_length - hlen : 16'd0;
        frag_end = {1'b0, offset} + {1'b0, payload};
        r.status = ifrt_pkg::STATUS_PASS;
        if (offset == 16'd0 && !more)
            return r;
        s = -1;
        for (i = 0; i < ifrt_pkg::SLOT_COUNT_DEF && s < 0; i++)
            if (slot_used[i] && slot_src[i] == w.src_addr && slot_ident[i] == w.ident)
                s = i;
        for (i = 0; i < ifrt_pkg::SLOT_COUNT_DEF && s < 0; i++)
        begin
            if (!slot_used[i])
            begin
                s = i;
                slot_used[i]     = 1'b1;
                slot_src[i]      = w.src_addr;
                slot_ident[i]    = w.ident;
                slot_hw[i]       = 16'd0;
                slot_expect[i]   = 16'd0;
                slot_deadline[i] = w.now_ms + {16'd0, cfg_timeout_ms};
            end
        end
        if (s < 0)
        begin
            r.status = ifrt_pkg::STATUS_DROP;
            n_dropped++;
            return r;
        end
        r.slot_index = 3'(s);
        if (frag_end <= 17'(ifrt_pkg::MAX_DATAGRAM_DEF))
        begin
            r.copy_payload = 1'b1;
            r.write_offset = offset;
            r.copy_length  = payload;
            if (frag_end[15:0] > slot_hw[s])
                slot_hw[s] = frag_end[15:0];
        end
        if (!more)
            slot_expect[s] = frag_end[16] ? 16'hFFFF : frag_end[15:0];
        if (slot_expect[s] != 16'd0 && slot_hw[s] >= slot_expect[s])
        begin
            r.status             = ifrt_pkg::STATUS_COMPLETE;
            r.reassembled_length = slot_expect[s];
            slot_used[s]         = 1'b0;
            n_reassembled++;
        end
        else
            r.status = ifrt_pkg::STATUS_STORED;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic req_word_t make_frag(logic [31:0] src, logic [15:0] id,
                                            logic [15:0] fw, logic [3:0] hw,
                                            logic [15:0] tlen);
        req_word_t w;
        w.kind         = ifrt_pkg::KIND_FRAG;
        w.now_ms       = 32'd0;
        w.src_addr     = src;
        w.ident        = id;
        w.frag_word    = fw;
        w.header_words = hw;
        w.total_length = tlen;
        return w;
    endfunction

    task automatic push_word(req_word_t w);
        w.now_ms = wall_ms;
        tx_backlog.push_back(w);
        words_queued++;
        wall_ms = wall_ms + $urandom_range(0, 150);
        if ($urandom_range(39) == 0)
            wall_ms = wall_ms + $urandom_range(1000, 9000);
    endtask

    task automatic push_frag(logic [31:0] src, logic [15:0] id, logic [15:0] fw,
                             logic [3:0] hw, logic [15:0] tlen);
        push_word(make_frag(src, id, fw, hw, tlen));
    endtask

    // other fields carry garbage, a tick must ignore them
    task automatic push_tick();
        req_word_t w;
        w = make_frag($urandom, 16'($urandom), 16'($urandom), 4'($urandom),
                      16'($urandom));
        w.kind = ifrt_pkg::KIND_TICK;
        push_word(w);
    endtask

    task automatic push_noise();
        push_frag($urandom, 16'($urandom), 16'($urandom), 4'($urandom), 16'($urandom));
    endtask

    task automatic add_datagram();
        logic [31:0] src;
        logic [15:0] id;
        logic [15:0] fw;
        int          nb;
        int          nfrag;
        int          off;
        int          chunk;
        int          plen;
        int          hw;
        int          tlen;
        int          f;
        src   = ($urandom_range(3) == 0) ? 32'hC0A8_0100 + $urandom_range(0, 3) : $urandom;
        id    = ($urandom_range(3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
        nb    = ($urandom_range(9) == 0) ? $urandom_range(6000, 8191) : $urandom_range(2, 64);
        nfrag = $urandom_range(2, (nb < 5) ? nb : 5);
        off   = 0;
        for (f = 0; f < nfrag; f++)
        begin
            if (f == nfrag - 1)
                chunk = nb - off;
            else
                chunk = $urandom_range(1, nb - off - (nfrag - 1 - f));
            plen = chunk * 8;
            if (f == nfrag - 1)
                plen = plen - $urandom_range(0, 7);
            hw   = ($urandom_range(15) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 15);
            tlen = plen + hw * 4;
            if (tlen > 65535)
                tlen = 65535;
            fw = {2'($urandom_range(0, 3)), (f != nfrag - 1), 13'(off)};
            // lost and repeated fragments
            if ($urandom_range(7) != 0)
                frag_batch.push_back(make_frag(src, id, fw, 4'(hw), 16'(tlen)));
            if ($urandom_range(11) == 0)
                frag_batch.push_back(make_frag(src, id, fw, 4'(hw), 16'(tlen)));
            off = off + chunk;
        end
    endtask

    task automatic flush_batch();
        req_word_t t;
        int        i;
        int        j;
        for (i = frag_batch.size() - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = frag_batch[i];
            frag_batch[i] = frag_batch[j];
            frag_batch[j] = t;
        end
        foreach (frag_batch[i])
        begin
            if ($urandom_range(9) == 0)
                push_tick();
            push_word(frag_batch[i]);
        end
        frag_batch.delete();
    endtask

    task automatic gen_random(int n);
        int target;
        int r;
        target = words_queued + n;
        while (words_queued < target)
        begin
            r = $urandom_range(99);
            if (r < 60)
            begin
                repeat ($urandom_range(1, 3)) add_datagram();
                flush_batch();
            end
            else if (r < 82)
                push_noise();
            else
                push_tick();
        end
    endtask

    task automatic write_reg(logic [ifrt_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == ifrt_pkg::REG_TIMEOUT)
            cfg_timeout_ms = val;
        else
            cfg_sweep_gap_ms = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (tx_backlog.size() != 0 || req_bus.valid || outstanding_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always #5 clk = ~clk;

    always @(posedge clk)
    begin : req_driver
        if (!rst_n)
            req_bus.valid <= 1'b0;
        else
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                outstanding_rsp.push_back(predict_reassembly(on_bus));
                words_sent++;
            end
            if (!req_bus.valid || req_bus.ready)
            begin
                if (tx_backlog.size() != 0 && (burst || $urandom_range(99) >= IDLE_PCT))
                begin
                    on_bus = tx_backlog.pop_front();
                    req_bus.kind         <= on_bus.kind;
                    req_bus.now_ms       <= on_bus.now_ms;
                    req_bus.src_addr     <= on_bus.src_addr;
                    req_bus.ident        <= on_bus.ident;
                    req_bus.frag_word    <= on_bus.frag_word;
                    req_bus.header_words <= on_bus.header_words;
                    req_bus.total_length <= on_bus.total_length;
                    req_bus.valid        <= 1'b1;
                end
                else
                    req_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : rsp_monitor
        rsp_word_t want;
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                words_seen++;
                if (outstanding_rsp.size() == 0)
                begin
                    $error("word on rsp with no result pending");
                    mismatches++;
                end
                else
                begin
                    want = outstanding_rsp.pop_front();
                    check_field("status", want.status, rsp_bus.status);
                    check_field("slot_index", want.slot_index, rsp_bus.slot_index);
                    check_field("copy_payload", want.copy_payload, rsp_bus.copy_payload);
                    check_field("write_offset", want.write_offset, rsp_bus.write_offset);
                    check_field("copy_length", want.copy_length, rsp_bus.copy_length);
                    check_field("reassembled_length", want.reassembled_length,
                                rsp_bus.reassembled_length);
                    check_field("expired_mask", want.expired_mask, rsp_bus.expired_mask);
                end
            end
            rsp_bus.ready <= burst || $urandom_range(99) >= IDLE_PCT;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = ifrt_pkg::REG_TIMEOUT;
        cfg_data             = 16'd0;
        req_bus.valid        = 1'b0;
        req_bus.kind         = ifrt_pkg::KIND_FRAG;
        req_bus.now_ms       = 32'd0;
        req_bus.src_addr     = 32'd0;
        req_bus.ident        = 16'd0;
        req_bus.frag_word    = 16'd0;
        req_bus.header_words = 4'd0;
        req_bus.total_length = 16'd0;
        rsp_bus.ready        = 1'b0;
        cfg_timeout_ms       = ifrt_pkg::TIMEOUT_RST;
        cfg_sweep_gap_ms     = ifrt_pkg::CLEANUP_RST;
        last_sweep_ms        = 32'd0;
        for (int i = 0; i < ifrt_pkg::SLOT_COUNT_DEF; i++)
            slot_used[i] = 1'b0;
        burst         = 1'b0;
        words_queued  = 0;
        words_sent    = 0;
        words_seen    = 0;
        mismatches    = 0;
        n_reassembled = 0;
        n_dropped     = 0;
        n_expired     = 0;
        n_sweeps      = 0;
        cycle_count   = 0;
        wall_ms       = 32'd2000;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at reset settings
        push_frag(32'hFFFF_FFFF, 16'hFFFF, 16'hC000, 4'd15, 16'hFFFF);
        push_frag(32'd0, 16'd0, 16'h2000, 4'd5, 16'd36);
        push_frag(32'd0, 16'd0, 16'h0002, 4'd5, 16'd28);
        push_frag(32'd1, 16'd0, 16'h2001, 4'd15, 16'd10);
        push_frag(32'd2, 16'd2, 16'h1FFF, 4'd0, 16'd100);
        push_frag(32'd2, 16'd2, 16'h2000, 4'd0, 16'hFFFF);
        for (int i = 10; i < 17; i++)
            push_frag(32'(i), 16'd7, 16'h2004, 4'd5, 16'd60);
        push_frag(32'd17, 16'd7, 16'h2004, 4'd5, 16'd60);
        push_frag(32'd1, 16'd0, 16'hE003, 4'd5, 16'd1500);
        wall_ms = 32'd3000;
        push_tick();
        push_tick();
        wall_ms = wall_ms + 32'd8000;
        push_tick();
        push_frag(32'd10, 16'd7, 16'h0008, 4'd5, 16'd20);
        push_frag(32'd5, 16'h1234, 16'h3FFF, 4'd1, 16'd0);
        wait_drained();

        write_reg(ifrt_pkg::REG_TIMEOUT, 16'd0);
        write_reg(ifrt_pkg::REG_CLEANUP, 16'd0);
        gen_random(160);
        wait_drained();

        write_reg(ifrt_pkg::REG_TIMEOUT, 16'hFFFF);
        write_reg(ifrt_pkg::REG_CLEANUP, 16'hFFFF);
        burst = 1'b1;
        gen_random(160);
        wait_drained();
        burst = 1'b0;

        // deadlines and sweep gaps across the 32-bit wrap
        write_reg(ifrt_pkg::REG_TIMEOUT, 16'd3000);
        write_reg(ifrt_pkg::REG_CLEANUP, 16'd250);
        wall_ms = 32'hFFFF_E000;
        gen_random(160);
        wait_drained();

        write_reg(ifrt_pkg::REG_TIMEOUT, ifrt_pkg::TIMEOUT_RST);
        write_reg(ifrt_pkg::REG_CLEANUP, ifrt_pkg::CLEANUP_RST);
        wall_ms = $urandom;
        gen_random(160);
        wait_drained();

        $display("run: %0d words in, %0d out, %0d reassembled, %0d dropped",
                 words_sent, words_seen, n_reassembled, n_dropped);
        $display("run: %0d sweeps freed %0d slots over five timeout settings",
                 n_sweeps, n_expired);
        if (mismatches == 0 && outstanding_rsp.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
